// ----- rtl/lmtpc_pkg.sv -----
// Package for the LFSR memory test pattern checker.
// Holds beat structs, register indexes, command codes and reset values.
// No dependencies.
package lmtpc_pkg;

  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] TAP_MASK_RST = 16'hB400;
  localparam logic [WORD_W-1:0] SEED_RST     = 16'h0001;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 2'd1;

  localparam logic CMD_GEN   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic              start_req;
    logic [WORD_W-1:0] read_word;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] pattern_word;
    logic [WORD_W-1:0] write_signature;
    logic [WORD_W-1:0] read_signature;
    logic              word_matched;
    logic              signatures_equal;
  } out_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] write_lfsr;
    logic [WORD_W-1:0] check_lfsr;
  } lfsr_state_t;

endpackage

// ----- rtl/lfsr_memory_test_pattern_checker.sv -----
// Top level of the LFSR memory test pattern checker: input register, config
// registers, LFSR state and result register. Depends on lmtpc_pkg, lmtpc_step.
//
//   channel | ports                               | beat
//   --------+-------------------------------------+----------------------
//   input   | in_valid, in_ready, in_beat         | cmd, start, read word
//   result  | out_valid, out_ready, out_beat      | pattern, signatures
//   config  | cfg_valid, cfg_ready, cfg_index/data| tap_mask, seed
//
// Beats pass the input register, then the result register; one beat per cycle
// sustained without result stalls, set by the single LFSR update between them.
// Reset loads tap_mask 0xB400, seed 0x0001 and both LFSRs with 0x0001.
// A stalled result holds the input register; in_ready then follows out_ready.
// Config writes are always accepted; cfg_ready is tied high.
module lfsr_memory_test_pattern_checker
  import lmtpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_beat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_beat,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  logic              in_vld_r;
  in_beat_t          in_r;
  logic              out_vld_r;
  out_beat_t         out_r;
  logic [WORD_W-1:0] tap_mask_r;
  logic [WORD_W-1:0] seed_r;
  lfsr_state_t       state_r;
  lfsr_state_t       state_nxt;
  out_beat_t         result;
  logic              s1_adv;

  lmtpc_step u_step (
    .item      (in_r),
    .tap_mask  (tap_mask_r),
    .seed      (seed_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign s1_adv    = !out_vld_r || out_ready;
  assign in_ready  = !in_vld_r || s1_adv;
  assign out_valid = out_vld_r;
  assign out_beat  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r           <= 1'b0;
      out_vld_r          <= 1'b0;
      tap_mask_r         <= TAP_MASK_RST;
      seed_r             <= SEED_RST;
      state_r.write_lfsr <= SEED_RST;
      state_r.check_lfsr <= SEED_RST;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (s1_adv) begin
        in_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= in_vld_r;
      end
      if (in_vld_r && s1_adv) begin
        state_r <= state_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TAP_MASK: tap_mask_r <= cfg_data;
          CFG_SEED:     seed_r     <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_beat;
    end
    if (in_vld_r && s1_adv) begin
      out_r <= result;
    end
  end

`ifndef ASSERT_OFF
  a_sig_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.write_signature == state_r.write_lfsr &&
                   out_r.read_signature == state_r.check_lfsr))
    else $error("held result signatures differ from LFSR state");

  a_sig_equal_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.signatures_equal ==
                   (out_r.write_signature == out_r.read_signature)))
    else $error("signatures_equal inconsistent with signatures");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !s1_adv) |=> (in_vld_r && $stable(in_r)))
    else $error("input register lost a stalled beat");

  a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(in_vld_r && s1_adv)) |=> $stable(state_r))
    else $error("LFSR state changed without a beat");
`endif

endmodule

// ----- rtl/lmtpc_step.sv -----
// Datapath for one beat: seed reload, check fold, Galois LFSR step, result.
// Purely combinational; depends on lmtpc_pkg.
module lmtpc_step
  import lmtpc_pkg::*;
(
  input  in_beat_t          item,
  input  logic [WORD_W-1:0] tap_mask,
  input  logic [WORD_W-1:0] seed,
  input  lfsr_state_t       state,
  output lfsr_state_t       state_nxt,
  output out_beat_t         result
);

  function automatic logic [WORD_W-1:0] lfsr_advance(input logic [WORD_W-1:0] s,
                                                     input logic [WORD_W-1:0] tap);
    logic [WORD_W-1:0] shifted;
    shifted = s >> 1;
    return s[0] ? (shifted ^ tap) : shifted;
  endfunction

  logic [WORD_W-1:0] cur_write;
  logic [WORD_W-1:0] cur_check;
  logic [WORD_W-1:0] folded;

  always_comb begin
    cur_write = (item.start_req && item.cmd == CMD_GEN) ? seed : state.write_lfsr;
    cur_check = (item.start_req && item.cmd == CMD_CHECK) ? seed : state.check_lfsr;
    folded    = cur_check + (cur_check ^ item.read_word);

    state_nxt = state;
    result    = '0;
    if (item.cmd == CMD_GEN) begin
      state_nxt.write_lfsr = lfsr_advance(cur_write, tap_mask);
      result.pattern_word  = cur_write;
    end else begin
      state_nxt.check_lfsr = lfsr_advance(folded, tap_mask);
      result.pattern_word  = cur_check;
      result.word_matched  = (item.read_word == cur_check);
    end
    result.write_signature  = state_nxt.write_lfsr;
    result.read_signature   = state_nxt.check_lfsr;
    result.signatures_equal = (state_nxt.write_lfsr == state_nxt.check_lfsr);
  end

endmodule

// ----- bench/lfsr_memory_test_pattern_checker_tb.sv -----
// Testbench for lfsr_memory_test_pattern_checker: directed corner cases, then
// write/read-back memory passes with random content, checked beat by beat.
// Depends on lmtpc_pkg and the lfsr_memory_test_pattern_checker RTL.
`timescale 1ns / 100ps

module lfsr_memory_test_pattern_checker_tb;
  import lmtpc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_beat_t             in_beat = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_beat;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  logic [WORD_W-1:0] model_tap = TAP_MASK_RST;
  logic [WORD_W-1:0] model_seed = SEED_RST;
  logic [WORD_W-1:0] model_write_lfsr = SEED_RST;
  logic [WORD_W-1:0] model_check_lfsr = SEED_RST;

  out_beat_t expected_results[$];
  out_beat_t oldest_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int matched_words = 0;
  int equal_signatures = 0;
  int stall_cycles = 0;

  lfsr_memory_test_pattern_checker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [WORD_W-1:0] lfsr_next(input logic [WORD_W-1:0] s,
                                                  input logic [WORD_W-1:0] taps);
    logic [WORD_W-1:0] shifted;
    shifted = s >> 1;
    if (s[0]) begin
      shifted = shifted ^ taps;
    end
    return shifted;
  endfunction

  task automatic predict_result(input in_beat_t b, output logic [WORD_W-1:0] pattern);
    out_beat_t         r;
    logic [WORD_W-1:0] folded;
    r = '0;
    if (b.cmd == CMD_GEN) begin
      if (b.start_req) begin
        model_write_lfsr = model_seed;
      end
      pattern = model_write_lfsr;
      model_write_lfsr = lfsr_next(model_write_lfsr, model_tap);
    end else begin
      if (b.start_req) begin
        model_check_lfsr = model_seed;
      end
      pattern = model_check_lfsr;
      r.word_matched = (b.read_word == model_check_lfsr);
      folded = model_check_lfsr + (model_check_lfsr ^ b.read_word);
      model_check_lfsr = lfsr_next(folded, model_tap);
    end
    r.pattern_word = pattern;
    r.write_signature = model_write_lfsr;
    r.read_signature = model_check_lfsr;
    r.signatures_equal = (model_write_lfsr == model_check_lfsr);
    expected_results.push_back(r);
  endtask

  task automatic send_beat(input in_beat_t b, output logic [WORD_W-1:0] pattern);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (!in_ready);
    predict_result(b, pattern);
    beats_sent++;
  endtask

  task automatic send_item(input logic cmd, input logic start, input logic [WORD_W-1:0] word);
    in_beat_t          b;
    logic [WORD_W-1:0] pattern;
    b.cmd = cmd;
    b.start_req = start;
    b.read_word = word;
    send_beat(b, pattern);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TAP_MASK: model_tap = data;
      CFG_SEED:     model_seed = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no input beat pending");
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("pattern_word", oldest_result.pattern_word, out_beat.pattern_word);
        check_field("write_signature", oldest_result.write_signature,
                    out_beat.write_signature);
        check_field("read_signature", oldest_result.read_signature, out_beat.read_signature);
        check_field("word_matched", WORD_W'(oldest_result.word_matched),
                    WORD_W'(out_beat.word_matched));
        check_field("signatures_equal", WORD_W'(oldest_result.signatures_equal),
                    WORD_W'(out_beat.signatures_equal));
        results_checked++;
        if (oldest_result.word_matched) matched_words++;
        if (oldest_result.signatures_equal) equal_signatures++;
      end
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_reset_values();
    send_item(CMD_GEN, 1'b0, 16'h0000);
    send_item(CMD_CHECK, 1'b0, SEED_RST);
    send_item(CMD_GEN, 1'b1, 16'hFFFF);
    send_item(CMD_CHECK, 1'b1, 16'hFFFF);
  endtask

  task automatic test_mode_corners();
    send_item(CMD_CHECK, 1'b0, 16'h0000);
    send_item(CMD_CHECK, 1'b0, model_check_lfsr);
    send_item(CMD_GEN, 1'b0, model_write_lfsr);
    send_item(CMD_GEN, 1'b0, 16'h5A5A);
  endtask

  task automatic test_config_registers();
    wait_idle();
    write_reg(CFG_TAP_MASK, 16'h0000);
    write_reg(CFG_SEED, 16'h0000);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h1234);
    send_item(CMD_GEN, 1'b1, 16'hAAAA);
    send_item(CMD_GEN, 1'b0, 16'h5555);
    send_item(CMD_CHECK, 1'b1, 16'h0000);
    send_item(CMD_CHECK, 1'b0, 16'hFFFF);
    wait_idle();
    write_reg(CFG_TAP_MASK, 16'hFFFF);
    write_reg(CFG_SEED, 16'hFFFF);
    send_item(CMD_GEN, 1'b1, 16'h0000);
    send_item(CMD_GEN, 1'b0, 16'h0000);
    send_item(CMD_CHECK, 1'b1, 16'hFFFF);
    send_item(CMD_CHECK, 1'b0, 16'h0000);
    wait_idle();
    write_reg(CFG_SEED, 16'h8001);
    send_item(CMD_GEN, 1'b0, 16'h0000);
    send_item(CMD_GEN, 1'b1, 16'h0000);
  endtask

  task automatic load_random_config();
    logic [WORD_W-1:0] taps;
    logic [WORD_W-1:0] seed_val;
    case ($urandom_range(5))
      0: taps = TAP_MASK_RST;
      1: taps = 16'hFFFF;
      2: taps = 16'h0000;
      default: taps = WORD_W'($urandom);
    endcase
    case ($urandom_range(5))
      0: seed_val = 16'h0000;
      1: seed_val = 16'hFFFF;
      default: seed_val = WORD_W'($urandom);
    endcase
    wait_idle();
    write_reg(CFG_TAP_MASK, taps);
    write_reg(CFG_SEED, seed_val);
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, WORD_W'($urandom));
    end
  endtask

  // Write a run of pattern words, then read them back, corrupting a few.
  task automatic run_memory_pass(output int n);
    logic [WORD_W-1:0] written[$];
    logic [WORD_W-1:0] pattern;
    in_beat_t          b;
    int                len;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      b.cmd = CMD_GEN;
      b.start_req = (i == 0);
      b.read_word = WORD_W'($urandom);
      send_beat(b, pattern);
      written.push_back(pattern);
    end
    for (int i = 0; i < len; i++) begin
      b.cmd = CMD_CHECK;
      b.start_req = (i == 0);
      b.read_word = written[i];
      if ($urandom_range(99) < 8) begin
        b.read_word = b.read_word ^ (16'h0001 << $urandom_range(15));
      end
      send_beat(b, pattern);
    end
    n = 2 * len;
  endtask

  task automatic test_random_memory_passes(input int n_items, input int send_pct,
                                           input int recv_pct);
    in_beat_t          b;
    logic [WORD_W-1:0] pattern;
    int                sent;
    int                n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int half = 0; half < 2; half++) begin
      load_random_config();
      sent = 0;
      while (sent < n_items / 2) begin
        if ($urandom_range(99) < 20) begin
          b.cmd = 1'($urandom_range(1));
          b.start_req = ($urandom_range(3) == 0);
          b.read_word = WORD_W'($urandom);
          send_beat(b, pattern);
          sent++;
        end else begin
          run_memory_pass(n);
          sent += n;
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_mode_corners();
    test_config_registers();
    test_random_memory_passes(184, 25, 69);
    test_random_memory_passes(184, 69, 25);
    test_random_memory_passes(184, 0, 0);
    wait_idle();
    $display("sent %0d beats, checked %0d results over %0d register writes",
             beats_sent, results_checked, cfg_writes);
    $display("read-back matches %0d, equal signatures %0d", matched_words, equal_signatures);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lmtpc_pkg.sv
rtl/lmtpc_step.sv
rtl/lfsr_memory_test_pattern_checker.sv
bench/lfsr_memory_test_pattern_checker_tb.sv
